// ----- hw/rtl/etb_pkg.sv -----
// ----------------------------------------------------------------------------
// etb_pkg
// Shared widths, codes and types of the event trajectory time binner.
// ----------------------------------------------------------------------------
`default_nettype none

package etb_pkg;

  localparam int unsigned MAX_BINS_DEF = 1024;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_IN_W   = 20;
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned DROP_W     = 16;
  localparam int unsigned BIN_W      = 10;
  localparam int unsigned START_W    = 26;
  localparam int unsigned STEP_W     = $clog2(TIME_W);

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 152;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] BIN_COUNT_RST = COUNT_W'(1024);
  localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST = WIDTH_W'(1);

  typedef enum logic [0:0] {
    OP_SAMPLE  = 1'b0,
    OP_READOUT = 1'b1
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BIN_WIDTH = 1'b0,
    CFG_BIN_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_READ
  } state_e;

  // three species values, first species in the low bits
  typedef struct packed {
    logic [SUM_W-1:0] c;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] a;
  } tri_t;

endpackage

`default_nettype wire

// ----- hw/rtl/event_trajectory_time_binner.sv -----
// ----------------------------------------------------------------------------
// event_trajectory_time_binner
// Bins a three-species trajectory onto a regular time grid and reads the
// bins back as running prefix sums.
// ----------------------------------------------------------------------------
// Input stream: tuser selects a sample (0) or a readout step (1); tdata holds
// the event time and three species counts. A sample adds its change since the
// previous sample into bin event_time / bin_width, or is dropped and counted
// when that bin is at or past bin_count. Each readout transfer emits one bin on
// the output stream as running sums plus the bin start time; tlast marks the
// final bin, after which the sample history, sums and drop count restart.
// Bins are kept in one MAX_BINS x 96 bit RAM, read and written back.
// Steps: a sample holds the input while the serial divider runs, then its bin
// is read from the RAM and written back; a dropped sample skips the RAM
// access. A readout does a RAM read, then a commit into the output
// register, which clears the bin.
// One item is in flight at a time; a sample is accepted while a result still
// waits in the output register. A readout waits in its commit cycle while the
// output register is full and the receiver stalls.
// After reset the RAM is swept to zero, one entry per cycle, over all MAX_BINS
// entries; the input is not ready meanwhile, configuration writes are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module event_trajectory_time_binner
  import etb_pkg::*;
#(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,

  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // event_time[31:0], species_a[51:32], species_b[71:52], species_c[91:72]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  wire logic                  s_axis_tuser,

  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // bin_number[9:0], bin_start_time[35:10], total_a[67:36], total_b[99:68],
  // total_c[131:100], dropped_samples[147:132]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(MAX_BINS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned PAD_W = OUT_DATA_W - (DROP_W + 3 * SUM_W + START_W + BIN_W);
  localparam int unsigned A_LO  = TIME_W;
  localparam int unsigned B_LO  = A_LO + CNT_IN_W;
  localparam int unsigned C_LO  = B_LO + CNT_IN_W;

  // configuration
  logic [WIDTH_W-1:0] width_q;
  logic [COUNT_W-1:0] count_q;
  logic [WIDTH_W-1:0] width_use;
  logic [CNT_W-1:0]   cnt_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= BIN_WIDTH_RST;
      count_q <= BIN_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_BIN_WIDTH: width_q <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_BIN_COUNT: count_q <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_use = (width_q == '0) ? WIDTH_W'(1) : width_q;

  always_comb begin
    if (count_q == '0) begin
      cnt_use = CNT_W'(1);
    end else if (32'(count_q) > 32'(MAX_BINS)) begin
      cnt_use = CNT_W'(MAX_BINS);
    end else begin
      cnt_use = CNT_W'(count_q);
    end
  end

  // state
  state_e              state_q, state_d;
  logic [IDX_W-1:0]    clr_q;
  logic                first_q;
  logic [CNT_IN_W-1:0] prev_a_q, prev_b_q, prev_c_q;
  tri_t                delta_q;
  tri_t                sums_q;
  logic [IDX_W-1:0]    ridx_q;
  logic [DROP_W-1:0]   drop_q;
  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                m_last_q;

  // bin memory
  tri_t                bin_mem [MAX_BINS];
  tri_t                rdata_q;
  logic                mem_re, mem_we;
  logic [IDX_W-1:0]    mem_addr;
  tri_t                mem_wdata;

  // divider
  logic                div_start, div_done;
  logic [TIME_W-1:0]   div_quo;
  logic                in_range;

  etb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_axis_tdata[TIME_W-1:0]),
    .divisor_i  (width_use),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_range = (div_quo < TIME_W'(cnt_use));

  // readout datapath
  logic                  accept, commit, is_last;
  logic [IDX_W:0]        ridx_p1;
  logic [IDX_W+WIDTH_W-1:0] start_full;
  tri_t                  sums_new;
  logic [CNT_IN_W-1:0]   now_a, now_b, now_c;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign ridx_p1    = {1'b0, ridx_q} + (IDX_W + 1)'(1);
  assign is_last    = ((IDX_W + 1)'(cnt_use) <= ridx_p1);
  assign start_full = ridx_q * width_use;
  assign sums_new.a = sums_q.a + rdata_q.a;
  assign sums_new.b = sums_q.b + rdata_q.b;
  assign sums_new.c = sums_q.c + rdata_q.c;
  assign now_a      = s_axis_tdata[A_LO +: CNT_IN_W];
  assign now_b      = s_axis_tdata[B_LO +: CNT_IN_W];
  assign now_c      = s_axis_tdata[C_LO +: CNT_IN_W];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == IDX_W'(MAX_BINS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == OP_READOUT) ? ST_READ : ST_DIV;
        end
      end
      ST_DIV:  if (div_done) state_d = in_range ? ST_ACC : ST_IDLE;
      ST_ACC:  state_d = ST_IDLE;
      ST_READ: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = ridx_q;
    mem_wdata     = '0;
    div_start     = 1'b0;
    commit        = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == OP_READOUT) begin
            mem_re = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        mem_addr = div_quo[IDX_W-1:0];
        mem_re   = div_done && in_range;
      end
      ST_ACC: begin
        mem_we      = 1'b1;
        mem_addr    = div_quo[IDX_W-1:0];
        mem_wdata.a = rdata_q.a + delta_q.a;
        mem_wdata.b = rdata_q.b + delta_q.b;
        mem_wdata.c = rdata_q.c + delta_q.c;
      end
      ST_READ: begin
        commit = !m_valid_q || m_axis_tready;
        mem_we = commit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= bin_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      first_q   <= 1'b1;
      prev_a_q  <= '0;
      prev_b_q  <= '0;
      prev_c_q  <= '0;
      sums_q    <= '0;
      ridx_q    <= '0;
      drop_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (accept && s_axis_tuser == OP_SAMPLE) begin
        first_q  <= 1'b0;
        prev_a_q <= now_a;
        prev_b_q <= now_b;
        prev_c_q <= now_c;
      end
      if (state_q == ST_DIV && div_done && !in_range && drop_q != '1) begin
        drop_q <= drop_q + DROP_W'(1);
      end
      if (commit) begin
        m_valid_q <= 1'b1;
        if (is_last) begin
          first_q  <= 1'b1;
          prev_a_q <= '0;
          prev_b_q <= '0;
          prev_c_q <= '0;
          sums_q   <= '0;
          ridx_q   <= '0;
          drop_q   <= '0;
        end else begin
          sums_q <= sums_new;
          ridx_q <= ridx_p1[IDX_W-1:0];
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser == OP_SAMPLE) begin
      delta_q.a <= first_q ? SUM_W'(now_a) : SUM_W'(now_a) - SUM_W'(prev_a_q);
      delta_q.b <= first_q ? SUM_W'(now_b) : SUM_W'(now_b) - SUM_W'(prev_b_q);
      delta_q.c <= first_q ? SUM_W'(now_c) : SUM_W'(now_c) - SUM_W'(prev_c_q);
    end
    if (commit) begin
      m_last_q <= is_last;
      m_data_q <= {PAD_W'(0), drop_q, sums_new.c, sums_new.b, sums_new.a,
                   START_W'(start_full), BIN_W'(ridx_q)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/etb_divider.sv -----
// ----------------------------------------------------------------------------
// etb_divider
// Restoring divider, one quotient bit per cycle: event time over bin width.
// ----------------------------------------------------------------------------
`default_nettype none

module etb_divider
  import etb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [TIME_W-1:0]  dividend_i,
  input  wire logic [WIDTH_W-1:0] divisor_i,
  output logic                    done_o,
  output logic [TIME_W-1:0]       quotient_o
);

  logic [TIME_W-1:0]  quo_q, quo_d;
  logic [WIDTH_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [WIDTH_W:0]   trial;
  logic [WIDTH_W:0]   diff;
  logic               fits;

  assign trial = {rem_q, quo_q[TIME_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[TIME_W-2:0], fits};
      rem_d  = fits ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(TIME_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
